// ===== hw/rtl/sparse_column_duplicate_merge_top_assert.svh =====
// Assertion macros for the column merge block
`ifndef SPARSE_COLUMN_DUPLICATE_MERGE_TOP_ASSERT_SVH
`define SPARSE_COLUMN_DUPLICATE_MERGE_TOP_ASSERT_SVH
// implication checked every cycle outside reset
`define SCDM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SCDM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/scdm_pkg.sv =====
package scdm_pkg;
    localparam int RowBits = 31;
    localparam int PtrBits = 31;
    localparam logic [PtrBits-1:0] TotalMax = {PtrBits{1'b1}};

    // command codes
    localparam logic CmdEntry = 1'b0;
    localparam logic CmdEnd   = 1'b1;
    // result kinds
    localparam logic KindEntry = 1'b0;
    localparam logic KindPtr   = 1'b1;

    // queue entry handed from front to back
    typedef struct packed {
        logic                cmd;
        logic [RowBits-1:0]  row;
        logic [31:0]         value;
    } t_item;

    // float add state between the align/add cycle and the normalize/round cycle
    typedef struct packed {
        logic        spec;   // special operand case, res is final
        logic [31:0] res;
        logic        sub;    // effective subtraction
        logic        s;
        logic [8:0]  e;
        logic [27:0] m;      // mantissa with guard, round and sticky bits
    } t_add_mid;

    // float32 add, first cycle: special operands, align and add
    function automatic t_add_mid f32_add_align(input logic [31:0] a, input logic [31:0] b);
        logic        sa, sb, tb;
        logic [8:0]  ea, eb, te, d;
        logic [27:0] ma, mb, tm, sh;
        t_add_mid    mid;
        sa = a[31]; sb = b[31];
        ea = {1'b0, a[30:23]}; eb = {1'b0, b[30:23]};
        ma = {5'd0, a[22:0]}; mb = {5'd0, b[22:0]};
        mid = '0;
        mid.spec = 1'b1;
        if (ea == 9'd255 && ma != '0) begin
            mid.res = a | 32'h0040_0000;
        end else if (eb == 9'd255 && mb != '0) begin
            mid.res = b | 32'h0040_0000;
        end else if (ea == 9'd255) begin
            mid.res = (eb == 9'd255 && sa != sb) ? 32'h7FC0_0000 : a;
        end else if (eb == 9'd255) begin
            mid.res = b;
        end else if (a[30:0] == '0 && b[30:0] == '0) begin
            mid.res = {sa & sb, 31'd0};
        end else if (a[30:0] == '0) begin
            mid.res = b;
        end else if (b[30:0] == '0) begin
            mid.res = a;
        end else begin
            mid.spec = 1'b0;
            if (ea == '0) ea = 9'd1; else ma[23] = 1'b1;
            if (eb == '0) eb = 9'd1; else mb[23] = 1'b1;
            ma = ma << 3; mb = mb << 3;
            if (ea < eb || (ea == eb && ma < mb)) begin
                tm = ma; ma = mb; mb = tm;
                te = ea; ea = eb; eb = te;
                tb = sa; sa = sb; sb = tb;
            end
            d = ea - eb;
            if (d >= 9'd28) begin
                mb = {27'd0, mb != '0};
            end else if (d != '0) begin
                sh = mb >> d[4:0];
                mb = sh | {27'd0, (sh << d[4:0]) != mb};
            end
            mid.s   = sa;
            mid.e   = ea;
            mid.sub = (sa != sb);
            if (sa == sb) begin
                mid.m = ma + mb;
                if (mid.m[27]) begin
                    mid.m = (mid.m >> 1) | {27'd0, mid.m[0]};
                    mid.e = ea + 9'd1;
                end
            end else begin
                mid.m = ma - mb;
            end
        end
        return mid;
    endfunction

    // float32 add, second cycle: normalize, round to nearest even, pack
    function automatic logic [31:0] f32_add_round(input t_add_mid mid);
        logic [8:0]  e;
        logic [27:0] m;
        logic [4:0]  lz;
        logic [2:0]  g;
        logic [24:0] r;
        logic [31:0] res;
        e   = mid.e;
        m   = mid.m;
        res = mid.res;
        if (!mid.spec) begin
            if (mid.sub && m == '0) begin
                res = '0;
            end else begin
                if (mid.sub) begin
                    // normalize: shift limited by exponent floor of 1
                    lz = '0;
                    for (int i = 26; i >= 0; i--) begin
                        if (m[i] == 1'b0 && lz == 5'(26 - i)) lz = 5'(27 - i);
                    end
                    if ({4'd0, lz} > e - 9'd1) lz = 5'(e - 9'd1);
                    m = m << lz;
                    e = e - {4'd0, lz};
                end
                g = m[2:0];
                r = {1'b0, m[26:3]};
                if (g > 3'd4 || (g == 3'd4 && r[0])) r = r + 25'd1;
                if (r[24]) begin
                    r = r >> 1;
                    e = e + 9'd1;
                end
                if (e >= 9'd255) res = {mid.s, 8'hFF, 23'd0};
                else res = {mid.s, r[23] ? e[7:0] : 8'd0, r[22:0]};
            end
        end
        return res;
    endfunction
endpackage

// ===== hw/rtl/scdm_front.sv =====
// Front: accepts items into a two-entry queue
module scdm_front import scdm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_item;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== hw/rtl/scdm_back.sv =====
// Back: merges runs, adds each entry in an align/add step and a registered normalize/round step, emits results
module scdm_back import scdm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_item              i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_kind,
    output logic [RowBits-1:0] o_row_out,
    output logic [31:0]        o_value_sum,
    output logic [PtrBits-1:0] o_col_ptr,
    output logic               o_overflow,
    output logic               o_last
);
    logic [RowBits-1:0] r_prow;
    logic               r_pvalid;
    logic [31:0]        r_psum;
    logic [PtrBits-1:0] r_total;
    logic               r_ovf;
    // second half of the float add in flight
    logic               r_busy;
    t_add_mid           r_mid;
    // output register; second slot holds pointer after a flushed run
    logic               r_ov, r_o2v;
    logic               r_kind, r_last;
    logic [RowBits-1:0] r_row;
    logic [31:0]        r_sum;
    logic [PtrBits-1:0] r_ptr;
    logic               r_oovf;
    logic [PtrBits-1:0] r_ptr2;
    logic               r_ovf2;
    logic               w_take, w_same, w_emit;
    t_add_mid           w_mid;

    assign o_valid     = r_ov;
    assign o_kind      = r_kind;
    assign o_row_out   = r_row;
    assign o_value_sum = r_sum;
    assign o_col_ptr   = r_ptr;
    assign o_overflow  = r_oovf;
    assign o_last      = r_last;

    // free output slot and finished sum needed for any item
    assign o_ready = !r_busy && !r_o2v && (!r_ov || i_ready);
    assign w_take  = i_valid && o_ready;
    assign w_same  = r_pvalid && (i_item.row == r_prow);
    assign w_emit  = (i_item.cmd == CmdEnd) || (r_pvalid && !w_same);
    assign w_mid   = f32_add_align(w_same ? r_psum : 32'd0, i_item.value);

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0; r_prow <= '0; r_psum <= '0;
            r_total <= '0; r_ovf <= 1'b0;
            r_busy <= 1'b0; r_mid <= '0;
        end else if (r_busy) begin
            r_busy <= 1'b0;
            r_psum <= f32_add_round(r_mid);
        end else if (w_take) begin
            if (i_item.cmd == CmdEnd) begin
                r_pvalid <= 1'b0; r_prow <= '0; r_psum <= '0;
            end else begin
                r_pvalid <= 1'b1;
                r_prow   <= i_item.row;
                r_mid    <= w_mid;
                r_busy   <= 1'b1;
                if (!w_same) begin
                    if (r_total == TotalMax) r_ovf <= 1'b1;
                    else r_total <= r_total + 1'b1;
                end
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_o2v <= 1'b0;
        end else if (w_take && w_emit) begin
            r_ov <= 1'b1;
            if (r_pvalid) begin
                r_kind <= KindEntry; r_row <= r_prow; r_sum <= r_psum;
                r_ptr <= '0; r_oovf <= 1'b0;
                r_last <= (i_item.cmd == CmdEntry);
                r_o2v  <= (i_item.cmd == CmdEnd);
                r_ptr2 <= r_total; r_ovf2 <= r_ovf;
            end else begin
                r_kind <= KindPtr; r_row <= '0; r_sum <= '0;
                r_ptr <= r_total; r_oovf <= r_ovf; r_last <= 1'b1;
            end
        end else if (r_ov && i_ready) begin
            if (r_o2v) begin
                r_o2v <= 1'b0;
                r_kind <= KindPtr; r_row <= '0; r_sum <= '0;
                r_ptr <= r_ptr2; r_oovf <= r_ovf2; r_last <= 1'b1;
            end else begin
                r_ov <= 1'b0;
            end
        end
    end
endmodule

// ===== hw/rtl/sparse_column_duplicate_merge_top.sv =====
// A result is registered in the back end when the back end takes the item that
// causes it. An entry holds the back end through align/add, then normalize/round,
// the sum feeding the next add; a column end that also flushes a run holds it
// until both the entry and the pointer results are taken. A two-entry queue lets
// the input burst.
// Synchronous active-low reset clears queue, run state, count and flag.
`include "sparse_column_duplicate_merge_top_assert.svh"
module sparse_column_duplicate_merge_top import scdm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [RowBits-1:0] i_row,
    input  logic [31:0]        i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_kind,
    output logic [RowBits-1:0] o_row_out,
    output logic [31:0]        o_value_sum,
    output logic [PtrBits-1:0] o_col_ptr,
    output logic               o_overflow,
    output logic               o_last
);
    t_item w_in, w_q;
    logic  w_qv, w_qr;

    assign w_in = '{cmd: i_command, row: i_row, value: i_value};

    scdm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_q)
    );

    scdm_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_item(w_q),
        .o_valid, .i_ready, .o_kind, .o_row_out, .o_value_sum, .o_col_ptr,
        .o_overflow, .o_last
    );

    // checks
    `SCDM_ASSERT_IMP(a_ptr_last, o_valid && o_kind == KindPtr, o_last)
    `SCDM_ASSERT_IMP(a_entry_clean, o_valid && o_kind == KindEntry, !o_overflow && o_col_ptr == '0)
    `SCDM_ASSERT_NXT(a_ovf_sticky, o_valid && o_kind == KindPtr && o_overflow, u_back.r_ovf)
endmodule
